>>> src/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

	localparam int TABLE_WORDS = 9;

	localparam logic [3:0] SPECIAL_LAST_PHASE = 4'd8;
	localparam logic [3:0] SQUARE_LAST_PHASE  = 4'd3;

	localparam logic [15:0] EFFECT_WAIT_RESET = 16'd1000;

	// request op codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// pattern modes
	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_EFFECTS = 2'd1;
	localparam logic [1:0] MODE_SQUARE  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_WAVE_FIRST   = 2'd0;
	localparam logic [1:0] CFG_WAVE_LAST    = 2'd1;
	localparam logic [1:0] CFG_REPEAT_LIMIT = 2'd2;
	localparam logic [1:0] CFG_EFFECT_WAIT  = 2'd3;

	// completion status
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef enum logic [2:0] {
		ACT_WAVE    = 3'd0,
		ACT_GO      = 3'd1,
		ACT_STANDBY = 3'd2,
		ACT_DRIVE   = 3'd3,
		ACT_AMP     = 3'd4,
		ACT_DONE    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_START,
		KIND_TICK
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot;
		logic [15:0] value;
		logic [1:0]  mode;
		logic [7:0]  amplitude;
		logic [7:0]  repeat_count;
	} entry_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] value;
		logic       status;
	} res_t;

endpackage

>>> src/hps_front.sv
`timescale 1ns / 1ps

module hps_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic [1:0]           op,
	input  logic [3:0]           word_index,
	input  logic [15:0]          word_value,
	input  logic [1:0]           mode,
	input  logic [7:0]           amplitude,
	input  logic [7:0]           repeat_count,
	output logic                 q_valid,
	input  logic                 q_pop,
	output hps_pkg::entry_t      q_head
);

	hps_pkg::entry_t entry;
	logic            keep;
	logic            push;

	hps_pkg::entry_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	// classify; ignored requests never reach the queue
	always_comb begin
		entry.slot         = word_index;
		entry.value        = word_value;
		entry.mode         = mode;
		entry.amplitude    = amplitude;
		entry.repeat_count = repeat_count;
		entry.kind         = hps_pkg::KIND_TICK;
		keep               = 1'b0;
		unique case (op)
			hps_pkg::OP_LOAD: begin
				entry.kind = hps_pkg::KIND_LOAD;
				keep       = (word_index < 4'(hps_pkg::TABLE_WORDS));
			end
			hps_pkg::OP_START: begin
				entry.kind = hps_pkg::KIND_START;
				keep       = 1'b1;
			end
			hps_pkg::OP_TICK: begin
				entry.kind = hps_pkg::KIND_TICK;
				keep       = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd_ready = (count_q != 2'd2);
	assign push      = cmd_valid && cmd_ready && keep;
	assign q_valid   = (count_q != 2'd0);
	assign q_head    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/hps_back.sv
`timescale 1ns / 1ps

module hps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            q_valid,
	output logic            q_pop,
	input  hps_pkg::entry_t q_head,
	output logic            act_valid,
	input  logic            act_ready,
	output logic [2:0]      action,
	output logic [7:0]      action_value,
	output logic            status,
	output logic            last
);

	function automatic hps_pkg::res_t mk_res(hps_pkg::action_t a, logic [7:0] v, logic s);
		hps_pkg::res_t r;
		r.action = a;
		r.value  = v;
		r.status = s;
		return r;
	endfunction

	// configuration
	logic [6:0]  wave_first_q;
	logic [6:0]  wave_last_q;
	logic [7:0]  repeat_limit_q;
	logic [15:0] effect_wait_q;

	// pattern state
	logic [15:0] tbl_q [hps_pkg::TABLE_WORDS];
	logic [1:0]  mode_q;
	logic [3:0]  phase_q;
	logic [7:0]  pass_q;
	logic [15:0] wait_q;
	logic [7:0]  rep_q;

	// result burst
	hps_pkg::res_t burst_q [3];
	logic          busy_q;
	logic [1:0]    idx_q;
	logic [1:0]    cnt_q;
	logic          is_last;

	logic [3:0]    next_phase;
	logic [15:0]   rd_word;
	logic          wave_ok;
	logic          sq_stop;

	logic [1:0]    n_mode;
	logic [3:0]    n_phase;
	logic [7:0]    n_pass;
	logic [15:0]   n_wait;
	logic [7:0]    n_rep;
	logic [1:0]    n_cnt;
	hps_pkg::res_t r0;
	hps_pkg::res_t r1;
	hps_pkg::res_t r2;
	hps_pkg::res_t idle_res;

	assign idle_res = mk_res(hps_pkg::ACT_STANDBY, 8'd0, hps_pkg::STATUS_OK);

	// step that the next tick or a start plays
	always_comb begin
		if (q_head.kind == hps_pkg::KIND_START) begin
			next_phase = 4'd0;
		end else if (mode_q == hps_pkg::MODE_SQUARE
				&& phase_q == hps_pkg::SQUARE_LAST_PHASE) begin
			next_phase = 4'd0;
		end else begin
			next_phase = phase_q + 4'd1;
		end
	end

	assign rd_word = (next_phase < 4'(hps_pkg::TABLE_WORDS)) ? tbl_q[next_phase] : 16'd0;
	assign wave_ok = (rd_word >= {9'd0, wave_first_q}) && (rd_word <= {9'd0, wave_last_q});
	assign sq_stop = (next_phase == hps_pkg::SQUARE_LAST_PHASE) && (pass_q == repeat_limit_q);

	always_comb begin
		n_mode  = mode_q;
		n_phase = phase_q;
		n_pass  = pass_q;
		n_wait  = wait_q;
		n_rep   = rep_q;
		n_cnt   = 2'd0;
		r0      = idle_res;
		r1      = idle_res;
		r2      = idle_res;
		unique case (q_head.kind)
			hps_pkg::KIND_LOAD: begin
				n_cnt = 2'd0;
			end
			hps_pkg::KIND_START: begin
				n_phase = 4'd0;
				n_pass  = 8'd0;
				n_wait  = 16'd0;
				n_rep   = q_head.repeat_count;
				n_mode  = hps_pkg::MODE_NONE;
				case (q_head.mode)
					hps_pkg::MODE_NONE: begin
						r1    = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_OK);
						n_cnt = 2'd2;
					end
					hps_pkg::MODE_EFFECTS: begin
						if (rd_word != 16'd0 && wave_ok) begin
							r0     = mk_res(hps_pkg::ACT_WAVE, rd_word[7:0], hps_pkg::STATUS_OK);
							r1     = mk_res(hps_pkg::ACT_GO, 8'd0, hps_pkg::STATUS_OK);
							n_cnt  = 2'd2;
							n_mode = hps_pkg::MODE_EFFECTS;
							n_wait = effect_wait_q;
						end else begin
							r1    = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_INVALID);
							n_cnt = 2'd2;
						end
					end
					hps_pkg::MODE_SQUARE: begin
						r0 = mk_res(hps_pkg::ACT_AMP, q_head.amplitude, hps_pkg::STATUS_OK);
						if (rd_word == 16'd0) begin
							r2    = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_INVALID);
							n_cnt = 2'd3;
						end else begin
							r1     = mk_res(hps_pkg::ACT_DRIVE, 8'd0, hps_pkg::STATUS_OK);
							n_cnt  = 2'd2;
							n_mode = hps_pkg::MODE_SQUARE;
							n_wait = rd_word;
						end
					end
					default: begin
						r1    = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_INVALID);
						n_cnt = 2'd2;
					end
				endcase
			end
			hps_pkg::KIND_TICK: begin
				if (mode_q == hps_pkg::MODE_NONE) begin
					n_cnt = 2'd0;
				end else if (wait_q > 16'd1) begin
					n_wait = wait_q - 16'd1;
				end else begin
					n_wait  = 16'd0;
					n_phase = next_phase;
					case (mode_q)
						hps_pkg::MODE_EFFECTS: begin
							if (next_phase > hps_pkg::SPECIAL_LAST_PHASE) begin
								r1     = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_OK);
								n_cnt  = 2'd2;
								n_mode = hps_pkg::MODE_NONE;
							end else if (next_phase[0]) begin
								// off-wait between effects
								n_wait = rd_word;
							end else if (wave_ok) begin
								r0     = mk_res(hps_pkg::ACT_WAVE, rd_word[7:0], hps_pkg::STATUS_OK);
								r1     = mk_res(hps_pkg::ACT_GO, 8'd0, hps_pkg::STATUS_OK);
								n_cnt  = 2'd2;
								n_wait = effect_wait_q;
							end else begin
								// a zero effect ends the pattern cleanly, an out-of-range one with invalid status
								r1     = mk_res(hps_pkg::ACT_DONE, 8'd0, rd_word != 16'd0);
								n_cnt  = 2'd2;
								n_mode = hps_pkg::MODE_NONE;
							end
						end
						hps_pkg::MODE_SQUARE: begin
							if (pass_q > rep_q) begin
								r1     = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_OK);
								n_cnt  = 2'd2;
								n_mode = hps_pkg::MODE_NONE;
							end else if (next_phase[0]) begin
								if (next_phase == hps_pkg::SQUARE_LAST_PHASE && !sq_stop) begin
									n_pass = pass_q + 8'd1;
								end
								if (rd_word == 16'd0) begin
									r2     = mk_res(hps_pkg::ACT_DONE, 8'd0,
										hps_pkg::STATUS_INVALID);
									n_cnt  = 2'd3;
									n_mode = hps_pkg::MODE_NONE;
								end else if (sq_stop) begin
									r2     = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_OK);
									n_cnt  = 2'd3;
									n_mode = hps_pkg::MODE_NONE;
								end else begin
									n_cnt  = 2'd1;
									n_wait = rd_word;
								end
							end else if (rd_word == 16'd0) begin
								r1     = mk_res(hps_pkg::ACT_DONE, 8'd0, hps_pkg::STATUS_INVALID);
								n_cnt  = 2'd2;
								n_mode = hps_pkg::MODE_NONE;
							end else begin
								r0     = mk_res(hps_pkg::ACT_DRIVE, 8'd0, hps_pkg::STATUS_OK);
								n_cnt  = 2'd1;
								n_wait = rd_word;
							end
						end
						default: begin
							n_mode = hps_pkg::MODE_NONE;
						end
					endcase
				end
			end
			default: begin
				n_cnt = 2'd0;
			end
		endcase
	end

	assign is_last      = (idx_q == cnt_q - 2'd1);
	assign q_pop        = q_valid && (!busy_q || (act_ready && is_last));
	assign act_valid    = busy_q;
	assign action       = burst_q[idx_q].action;
	assign action_value = burst_q[idx_q].value;
	assign status       = burst_q[idx_q].status;
	assign last         = is_last;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_head.kind == hps_pkg::KIND_LOAD) begin
				tbl_q[q_head.slot] <= q_head.value;
			end
			burst_q[0] <= r0;
			burst_q[1] <= r1;
			burst_q[2] <= r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_first_q   <= 7'd1;
			wave_last_q    <= 7'd123;
			repeat_limit_q <= 8'd255;
			effect_wait_q  <= hps_pkg::EFFECT_WAIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hps_pkg::CFG_WAVE_FIRST:   wave_first_q   <= cfg_data[6:0];
				hps_pkg::CFG_WAVE_LAST:    wave_last_q    <= cfg_data[6:0];
				hps_pkg::CFG_REPEAT_LIMIT: repeat_limit_q <= cfg_data[7:0];
				default:                   effect_wait_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= hps_pkg::MODE_NONE;
			phase_q <= 4'd0;
			pass_q  <= 8'd0;
			wait_q  <= 16'd0;
			rep_q   <= 8'd0;
			busy_q  <= 1'b0;
			idx_q   <= 2'd0;
			cnt_q   <= 2'd0;
		end else begin
			if (q_pop) begin
				mode_q  <= n_mode;
				phase_q <= n_phase;
				pass_q  <= n_pass;
				wait_q  <= n_wait;
				rep_q   <= n_rep;
				busy_q  <= (n_cnt != 2'd0);
				idx_q   <= 2'd0;
				cnt_q   <= n_cnt;
			end else if (busy_q && act_ready) begin
				// advance through the burst, drop busy after its final result
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

>>> src/haptic_pattern_sequencer.sv
`timescale 1ns / 1ps

// Haptic pattern sequencer: turns load, start and millisecond-tick requests into
// actuator commands (set waveform, go, standby, realtime drive, set amplitude, done).
// Request channel cmd_valid/cmd_ready carries op and its fields; result channel
// act_valid/act_ready carries one command per transfer, with last marking the final
// command caused by a request. A request may cause zero to three commands.
// The first command of a request is presented once the request has passed the queue
// and been registered into the burst. A two-entry queue sits between the request
// decoder and the pattern engine; the engine takes one queued request per cycle
// while no command burst is pending, so throughput is one request per cycle for
// requests with no commands; a request with commands holds the engine until the
// single result port drains its burst; the next is taken with the last command.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while no request is in flight, which the block does not enforce; writes take effect at once.
// Reset (arst_n low) empties the queue, drops any pending burst, stops playback
// and restores the configuration defaults; the pattern table keeps no reset value.
// When the receiver holds act_ready low the burst holds, the engine stops taking
// from the queue, and cmd_ready falls once the queue is full.
module haptic_pattern_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  word_index,
	input  logic [15:0] word_value,
	input  logic [1:0]  mode,
	input  logic [7:0]  amplitude,
	input  logic [7:0]  repeat_count,
	output logic        act_valid,
	input  logic        act_ready,
	output logic [2:0]  action,
	output logic [7:0]  action_value,
	output logic        status,
	output logic        last
);

	logic            q_valid;
	logic            q_pop;
	hps_pkg::entry_t q_head;

	hps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.op           (op),
		.word_index   (word_index),
		.word_value   (word_value),
		.mode         (mode),
		.amplitude    (amplitude),
		.repeat_count (repeat_count),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_head       (q_head)
	);

	hps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_head       (q_head),
		.act_valid    (act_valid),
		.act_ready    (act_ready),
		.action       (action),
		.action_value (action_value),
		.status       (status),
		.last         (last)
	);

endmodule
